/* design/oair_pkg.sv */
// ---------------------------------------------------------------------------
// oair_pkg: shared types and codes of the ordered array core
// Command codes, result status codes and the job descriptor that the front
// end hands to the back end through the job queue.
// ---------------------------------------------------------------------------
package oair_pkg;

	// Field widths of the stream words.
	localparam int unsigned CMD_W    = 2;
	localparam int unsigned POS_W    = 7;
	localparam int unsigned VAL_W    = 32;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned FPOS_W   = 6;
	localparam int unsigned ECNT_W   = 7;

	// Incoming command codes.
	localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
	localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd3;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	// Work that the back end carries out for one job.
	localparam int unsigned OP_W = 3;
	localparam logic [OP_W-1:0] OP_NONE   = 3'd0;
	localparam logic [OP_W-1:0] OP_APPEND = 3'd1;
	localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
	localparam logic [OP_W-1:0] OP_REMOVE = 3'd3;
	localparam logic [OP_W-1:0] OP_SEARCH = 3'd4;

	// Control part of a classified job.
	typedef struct packed {
		logic [OP_W-1:0]     op;
		logic [STATUS_W-1:0] status;
	} job_ctl_t;

endpackage

/* design/oair_front.sv */
// ---------------------------------------------------------------------------
// oair_front: command intake and classification
// Accepts command words, keeps a running copy of the entry count and decides
// for each command its status and the work the back end has to do.
// ---------------------------------------------------------------------------
module oair_front import oair_pkg::*; #(
	parameter int unsigned DEPTH = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [CMD_W-1:0]    cmd,
	input  logic [POS_W-1:0]    position,
	input  logic                q_ready,
	output logic                q_push,
	output job_ctl_t            job_ctl,
	output logic [$clog2(DEPTH+1)-1:0] job_cnt
);

	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_next;
	logic [CMP_W-1:0] pos_x;
	logic [CMP_W-1:0] cnt_x;
	logic             full;

	assign s_tready = q_ready;
	assign q_push   = s_tvalid && q_ready;
	assign job_cnt  = cnt_q;

	assign pos_x = CMP_W'(position);
	assign cnt_x = CMP_W'(cnt_q);
	assign full  = (cnt_q == CNT_W'(DEPTH));

	// Classify the command against the count left by all earlier commands.
	always_comb begin
		job_ctl.op     = OP_NONE;
		job_ctl.status = ST_OK;
		cnt_next       = cnt_q;
		unique case (cmd)
			CMD_APPEND: begin
				if (full) begin
					job_ctl.status = ST_FULL;
				end else begin
					job_ctl.op = OP_APPEND;
					cnt_next   = cnt_q + CNT_W'(1);
				end
			end
			CMD_INSERT: begin
				if (pos_x > cnt_x) begin
					job_ctl.status = ST_RANGE;
				end else if (full) begin
					job_ctl.status = ST_FULL;
				end else begin
					job_ctl.op = OP_INSERT;
					cnt_next   = cnt_q + CNT_W'(1);
				end
			end
			CMD_REMOVE: begin
				if (pos_x >= cnt_x) begin
					job_ctl.status = ST_RANGE;
				end else begin
					job_ctl.op = OP_REMOVE;
					cnt_next   = cnt_q - CNT_W'(1);
				end
			end
			default: begin
				job_ctl.op = OP_SEARCH;
			end
		endcase
	end

	// Running entry count as seen by the intake side.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (q_push) begin
			cnt_q <= cnt_next;
		end
	end

endmodule

/* design/oair_queue.sv */
// ---------------------------------------------------------------------------
// oair_queue: two-slot job queue
// Decouples the command intake from the array engine so that either side
// can stall without holding up the other.
// ---------------------------------------------------------------------------
module oair_queue #(
	parameter int unsigned W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         in_ready,
	input  logic         pop,
	output logic         out_valid,
	output logic [W-1:0] out_data
);

	logic [W-1:0] slot_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   fill_q;

	assign in_ready  = (fill_q != 2'd2);
	assign out_valid = (fill_q != 2'd0);
	assign out_data  = slot_q[rd_ptr_q];

	// Slot storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule

/* design/oair_back.sv */
// ---------------------------------------------------------------------------
// oair_back: array engine and result register
// Owns the entry memory. Shifts entries one per cycle for insert and remove,
// scans entries one per cycle for search, then loads the result register.
// ---------------------------------------------------------------------------
module oair_back import oair_pkg::*; #(
	parameter int unsigned DEPTH = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_valid,
	output logic                       q_pop,
	input  job_ctl_t                   q_ctl,
	input  logic [$clog2(DEPTH+1)-1:0] q_cnt,
	input  logic [POS_W-1:0]           q_pos,
	input  logic [VAL_W-1:0]           q_val,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [STATUS_W-1:0]        status,
	output logic                       found,
	output logic [FPOS_W-1:0]          found_position,
	output logic [ECNT_W-1:0]          entry_count
);

	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam int unsigned IDX_W = $clog2(DEPTH);
	localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	localparam logic [1:0] B_IDLE = 2'd0;
	localparam logic [1:0] B_RUN  = 2'd1;
	localparam logic [1:0] B_FIN  = 2'd2;
	localparam logic [1:0] B_DONE = 2'd3;

	logic [1:0]          state_q;
	logic [OP_W-1:0]     op_q;
	logic [STATUS_W-1:0] status_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [VAL_W-1:0]    val_q;
	logic [IDX_W-1:0]    tgt_q;
	logic [IDX_W-1:0]    rd_ptr_q;
	logic [CNT_W-1:0]    rd_left_q;
	logic                hit_q;
	logic [IDX_W-1:0]    hit_pos_q;
	logic                v_s1;
	logic [IDX_W-1:0]    addr_s1;
	logic [VAL_W-1:0]    rd_data_s1;
	logic                out_valid_q;

	logic [VAL_W-1:0]    mem_q [DEPTH];

	logic                issue;
	logic                hit_now;
	logic                wr_en;
	logic [IDX_W-1:0]    wr_addr;
	logic [VAL_W-1:0]    wr_data;
	logic                out_load;
	logic [CMP_W-1:0]    pos_x;
	logic [CMP_W-1:0]    cnt_x;
	logic [CNT_W-1:0]    rd_left_init;
	logic [IDX_W-1:0]    rd_ptr_init;
	logic [CNT_W-1:0]    cnt_after;

	assign pos_x = CMP_W'(q_pos);
	assign cnt_x = CMP_W'(q_cnt);

	// Sweep length and start address for a new job.
	always_comb begin
		rd_left_init = '0;
		rd_ptr_init  = '0;
		unique case (q_ctl.op)
			OP_INSERT: begin
				rd_left_init = CNT_W'(cnt_x - pos_x);
				rd_ptr_init  = IDX_W'(cnt_x - CMP_W'(1));
			end
			OP_REMOVE: begin
				rd_left_init = CNT_W'(cnt_x - pos_x - CMP_W'(1));
				rd_ptr_init  = IDX_W'(pos_x + CMP_W'(1));
			end
			OP_SEARCH: begin
				rd_left_init = q_cnt;
			end
			default: begin
				rd_left_init = '0;
			end
		endcase
	end

	// Read issue and search compare.
	assign hit_now = v_s1 && (op_q == OP_SEARCH) && (rd_data_s1 == val_q);
	assign issue   = (state_q == B_RUN) && (rd_left_q != '0) && !hit_q && !hit_now;
	assign q_pop   = (state_q == B_IDLE) && q_valid;
	assign out_load = (state_q == B_DONE) && (!out_valid_q || m_tready);

	// Write port: shifted entries during the sweep, the new value at the end.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = tgt_q;
		wr_data = val_q;
		if (state_q == B_FIN) begin
			wr_en = 1'b1;
		end else if (v_s1 && (op_q == OP_INSERT)) begin
			wr_en   = 1'b1;
			wr_addr = addr_s1 + IDX_W'(1);
			wr_data = rd_data_s1;
		end else if (v_s1 && (op_q == OP_REMOVE)) begin
			wr_en   = 1'b1;
			wr_addr = addr_s1 - IDX_W'(1);
			wr_data = rd_data_s1;
		end
	end

	// Count after the job completes.
	always_comb begin
		unique case (op_q)
			OP_APPEND, OP_INSERT: cnt_after = cnt_q + CNT_W'(1);
			OP_REMOVE:            cnt_after = cnt_q - CNT_W'(1);
			default:              cnt_after = cnt_q;
		endcase
	end

	// Entry memory with registered read data.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (issue) begin
			rd_data_s1 <= mem_q[rd_ptr_q];
		end
	end

	// Job payload and read pipeline address.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			status_q <= q_ctl.status;
			cnt_q    <= q_cnt;
			val_q    <= q_val;
			tgt_q    <= (q_ctl.op == OP_APPEND) ? IDX_W'(q_cnt) : IDX_W'(q_pos);
		end
		if (issue) begin
			addr_s1 <= rd_ptr_q;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			op_q      <= OP_NONE;
			rd_ptr_q  <= '0;
			rd_left_q <= '0;
			hit_q     <= 1'b0;
			hit_pos_q <= '0;
			v_s1      <= 1'b0;
		end else begin
			v_s1 <= issue;
			unique case (state_q)
				B_IDLE: begin
					if (q_valid) begin
						op_q      <= q_ctl.op;
						rd_ptr_q  <= rd_ptr_init;
						rd_left_q <= rd_left_init;
						hit_q     <= 1'b0;
						hit_pos_q <= '0;
						state_q   <= B_RUN;
					end
				end
				B_RUN: begin
					if (hit_now) begin
						hit_q     <= 1'b1;
						hit_pos_q <= addr_s1;
					end
					if (issue) begin
						rd_left_q <= rd_left_q - CNT_W'(1);
						if (op_q == OP_INSERT) begin
							rd_ptr_q <= rd_ptr_q - IDX_W'(1);
						end else begin
							rd_ptr_q <= rd_ptr_q + IDX_W'(1);
						end
					end else if ((op_q == OP_INSERT) || (op_q == OP_APPEND)) begin
						state_q <= B_FIN;
					end else begin
						state_q <= B_DONE;
					end
				end
				B_FIN: begin
					state_q <= B_DONE;
				end
				default: begin
					if (out_load) begin
						state_q <= B_IDLE;
					end
				end
			endcase
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			status         <= status_q;
			found          <= hit_q;
			found_position <= FPOS_W'(hit_pos_q);
			entry_count    <= ECNT_W'(cnt_after);
		end
	end

	assign m_tvalid = out_valid_q;

	// A memory write only happens while a job is being carried out.
	a_wr_in_job: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> ((state_q == B_RUN) || (state_q == B_FIN)))
		else $error("entry memory written outside a job");

	// The final value write belongs to append and insert only.
	a_fin_op: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_FIN) |-> ((op_q == OP_INSERT) || (op_q == OP_APPEND)))
		else $error("value write for a job that does not add an entry");

	// A hit can only come from a search.
	a_hit_search: assert property (@(posedge clk) disable iff (!arst_n)
		hit_q |-> (op_q == OP_SEARCH))
		else $error("search hit flagged for another command");

	// No read is still in flight when the result is loaded.
	a_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_DONE) |-> !v_s1)
		else $error("result loaded with a memory read outstanding");

endmodule

/* design/ordered_array_insert_remove_search_core.sv */
// ---------------------------------------------------------------------------
// ordered_array_insert_remove_search_core: ordered array with insert/remove/search
// Path of a command word: intake and classification, job queue, engine sweep
//   that moves (insert, remove) or compares (search) entries, a final value
//   write for insert and append, then the result register; error results skip the sweep.
// Commands: the two-slot job queue takes new commands while the engine works on
//   an earlier one; the single entry memory moves or compares one entry per cycle.
// Reset: entry count zero, job queue and result register empty; memory
//   contents are not cleared.
// ---------------------------------------------------------------------------
module ordered_array_insert_remove_search_core import oair_pkg::*; #(
	parameter int unsigned DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // position[6:0], item_value[38:7], zero[39]
	input  logic [1:0]  s_tuser,  // cmd[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // status[1:0], found[2], found_position[8:3],
	                              // entry_count[15:9]
);

	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam int unsigned REC_W = $bits(job_ctl_t) + CNT_W + POS_W + VAL_W;

	job_ctl_t            f_ctl;
	logic [CNT_W-1:0]    f_cnt;
	logic                f_push;
	logic                q_ready;
	logic                q_valid;
	logic                q_pop;
	logic [REC_W-1:0]    q_in;
	logic [REC_W-1:0]    q_out;
	job_ctl_t            b_ctl;
	logic [CNT_W-1:0]    b_cnt;
	logic [POS_W-1:0]    b_pos;
	logic [VAL_W-1:0]    b_val;
	logic [STATUS_W-1:0] r_status;
	logic                r_found;
	logic [FPOS_W-1:0]   r_fpos;
	logic [ECNT_W-1:0]   r_ecnt;

	// Intake and classification.
	oair_front #(.DEPTH(DEPTH)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.cmd      (s_tuser),
		.position (s_tdata[6:0]),
		.q_ready  (q_ready),
		.q_push   (f_push),
		.job_ctl  (f_ctl),
		.job_cnt  (f_cnt)
	);

	assign q_in = {f_ctl, f_cnt, s_tdata[6:0], s_tdata[38:7]};

	// Job queue between intake and engine.
	oair_queue #(.W(REC_W)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (f_push),
		.push_data (q_in),
		.in_ready  (q_ready),
		.pop       (q_pop),
		.out_valid (q_valid),
		.out_data  (q_out)
	);

	assign {b_ctl, b_cnt, b_pos, b_val} = q_out;

	// Array engine.
	oair_back #(.DEPTH(DEPTH)) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (q_valid),
		.q_pop          (q_pop),
		.q_ctl          (b_ctl),
		.q_cnt          (b_cnt),
		.q_pos          (b_pos),
		.q_val          (b_val),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.status         (r_status),
		.found          (r_found),
		.found_position (r_fpos),
		.entry_count    (r_ecnt)
	);

	assign m_tdata = {r_ecnt, r_fpos, r_found, r_status};

endmodule

/* verif/ordered_array_checker.sv */
// ---------------------------------------------------------------------------
// ordered_array_checker: result predictor and scoreboard of the ordered array
// Watches the command and result channels, keeps its own copy of the entry
// table and count, works out the result word of every accepted command and
// compares each result word against the oldest one still owed.
// ---------------------------------------------------------------------------
module ordered_array_checker import oair_pkg::*; #(
	parameter int unsigned DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [39:0] s_tdata,  // position[6:0], item_value[38:7], zero[39]
	input  logic [1:0]  s_tuser,  // cmd[1:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,  // status[1:0], found[2], found_position[8:3],
	                              // entry_count[15:9]
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// Fields of one result word.
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                found;
		logic [FPOS_W-1:0]   found_pos;
		logic [ECNT_W-1:0]   entry_count;
	} reply_t;

	// Shadow copy of the table.
	logic [VAL_W-1:0] slots [DEPTH];
	int unsigned      stored = 0;
	int               errors = 0;
	reply_t           replies_due [$];

	// Apply one command to the shadow table and return the word it must produce.
	function automatic reply_t execute_command(logic [CMD_W-1:0] cmd,
			logic [POS_W-1:0] pos, logic [VAL_W-1:0] val);
		reply_t r;
		int unsigned i;
		r = '0;
		r.status = ST_OK;
		unique case (cmd)
			CMD_APPEND: begin
				if (stored >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					slots[stored] = val;
					stored++;
				end
			end
			CMD_INSERT: begin
				// The range check wins over the full check.
				if (pos > stored) begin
					r.status = ST_RANGE;
				end else if (stored >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					for (i = stored; i > pos; i--)
						slots[i] = slots[i-1];
					slots[pos] = val;
					stored++;
				end
			end
			CMD_REMOVE: begin
				if (pos >= stored) begin
					r.status = ST_RANGE;
				end else begin
					for (i = pos; i + 1 < stored; i++)
						slots[i] = slots[i+1];
					stored--;
				end
			end
			CMD_SEARCH: begin
				// The lowest matching index is reported.
				for (i = 0; i < stored; i++) begin
					if (!r.found && slots[i] == val) begin
						r.found = 1'b1;
						r.found_pos = i[FPOS_W-1:0];
					end
				end
			end
		endcase
		r.entry_count = stored[ECNT_W-1:0];
		return r;
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	// Compare result words first, then queue the prediction for a new command.
	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		reply_t got;
		if (!arst_n) begin
			stored = 0;
			replies_due.delete();
			pending <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.status      = m_tdata[1:0];
				got.found       = m_tdata[2];
				got.found_pos   = m_tdata[8:3];
				got.entry_count = m_tdata[15:9];
				if (replies_due.size() == 0) begin
					$error("result word %h arrived with no command outstanding", m_tdata);
					errors++;
				end else begin
					want = replies_due.pop_front();
					check_field("status", want.status, got.status);
					check_field("found", want.found, got.found);
					check_field("found_position", want.found_pos, got.found_pos);
					check_field("entry_count", want.entry_count, got.entry_count);
				end
			end
			if (s_tvalid && s_tready)
				replies_due = {replies_due,
					execute_command(s_tuser, s_tdata[6:0], s_tdata[38:7])};
			pending <= replies_due.size();
		end
		fail_count <= errors;
	end

endmodule

/* verif/tb_ordered_array_insert_remove_search_core.sv */
// ---------------------------------------------------------------------------
// tb_ordered_array_insert_remove_search_core: testbench of the ordered array
// Sends a directed set of commands that hits the value extremes and the range
// error status, then random command streams that fill the table to capacity
// and drain it again, with random gaps on both channels. A separate checker
// predicts and compares every result word.
// ---------------------------------------------------------------------------
module tb_ordered_array_insert_remove_search_core import oair_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned DEPTH = 64;
	localparam int unsigned RANDOM_WORDS = 380;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;   // position[6:0], item_value[38:7], zero[39]
	logic [1:0]  s_tuser = '0;   // cmd[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;        // status[1:0], found[2], found_position[8:3],
	                             // entry_count[15:9]
	int          fail_count;
	int          pending;

	// No gaps on either side while this is set.
	bit          steady = 1'b0;
	// Entry count as seen from the sender, used to aim positions and to switch between filling and draining.
	int unsigned fill = 0;
	bit          growing = 1'b1;

	// Small set of values so that searches hit and duplicates occur.
	logic [VAL_W-1:0] value_pool [8] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
		32'hFFFF_FFFF, 32'h0000_0001, 32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678};

	ordered_array_insert_remove_search_core #(.DEPTH(DEPTH)) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	ordered_array_checker #(.DEPTH(DEPTH)) checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #5 clk = ~clk;

	// Result side backpressure.
	always @(posedge clk) begin
		m_tready <= steady || ($urandom_range(99) >= 35);
	end

	// Send one command word, with a random gap ahead of it.
	task automatic send_word(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
			logic [VAL_W-1:0] val);
		while (!steady && $urandom_range(99) < 35) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {1'b0, val, pos};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		unique case (cmd)
			CMD_APPEND: if (fill < DEPTH) fill++;
			CMD_INSERT: if (pos <= fill && fill < DEPTH) fill++;
			CMD_REMOVE: if (pos < fill) fill--;
			default: ;
		endcase
	endtask

	// Random command, biased toward filling or draining the table.
	task automatic send_random();
		logic [CMD_W-1:0] cmd;
		logic [POS_W-1:0] pos;
		logic [VAL_W-1:0] val;
		int unsigned roll;
		roll = $urandom_range(99);
		if (growing)
			cmd = roll < 45 ? CMD_APPEND : roll < 75 ? CMD_INSERT :
				roll < 85 ? CMD_REMOVE : CMD_SEARCH;
		else
			cmd = roll < 10 ? CMD_APPEND : roll < 20 ? CMD_INSERT :
				roll < 85 ? CMD_REMOVE : CMD_SEARCH;
		pos = POS_W'($urandom_range(127));
		if ($urandom_range(99) < 85) begin
			if (cmd == CMD_INSERT)
				pos = POS_W'($urandom_range(fill, 0));
			else if (cmd == CMD_REMOVE && fill > 0)
				pos = POS_W'($urandom_range(fill - 1, 0));
		end
		val = ($urandom_range(1) == 0) ? value_pool[$urandom_range(7)] : $urandom();
		send_word(cmd, pos, val);
		if (growing && fill == DEPTH && $urandom_range(3) == 0)
			growing = 1'b0;
		else if (!growing && fill == 0)
			growing = 1'b1;
	endtask

	// Main sequence.
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty table: search miss, remove and insert out of range.
		send_word(CMD_SEARCH, 7'd0, 32'd5);
		send_word(CMD_REMOVE, 7'd0, 32'd0);
		send_word(CMD_INSERT, 7'd1, 32'd9);
		// Value extremes, insert at the front, at the end and in the middle.
		send_word(CMD_INSERT, 7'd0, 32'h7FFF_FFFF);
		send_word(CMD_APPEND, 7'd127, 32'h8000_0000);
		send_word(CMD_APPEND, 7'd0, 32'h0000_0000);
		send_word(CMD_APPEND, 7'd64, 32'hFFFF_FFFF);
		send_word(CMD_INSERT, 7'd4, 32'h1234_5678);
		send_word(CMD_INSERT, 7'd2, 32'h7FFF_FFFF);
		// Duplicate value reports its lowest index; near miss differs in one bit.
		send_word(CMD_SEARCH, 7'd127, 32'h7FFF_FFFF);
		send_word(CMD_SEARCH, 7'd0, 32'h8000_0000);
		send_word(CMD_SEARCH, 7'd0, 32'h7FFF_FFFE);
		send_word(CMD_INSERT, 7'd127, 32'd1);
		// Remove one past the end, then the last, the first and a middle entry.
		send_word(CMD_REMOVE, 7'd6, 32'hFFFF_FFFF);
		send_word(CMD_REMOVE, 7'd5, 32'd0);
		send_word(CMD_REMOVE, 7'd0, 32'd0);
		send_word(CMD_REMOVE, 7'd2, 32'd0);
		send_word(CMD_SEARCH, 7'd0, 32'h1234_5678);
		send_word(CMD_APPEND, 7'd0, 32'h5555_5555);
		send_word(CMD_APPEND, 7'd0, 32'hAAAA_AAAA);
		send_word(CMD_SEARCH, 7'd0, 32'hAAAA_AAAA);
		send_word(CMD_REMOVE, 7'd64, 32'd0);

		// Random streams; the full-table cases come up once the table fills.
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			steady = (n >= 150 && n < 230);
			send_random();
		end
		steady = 1'b0;
		s_tvalid <= 1'b0;

		// Let the checker see the last command, then drain the results.
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// Run time limit.
	initial begin
		#5ms;
		$display("simulation failed");
		$finish;
	end

endmodule
